// ===== sv/htw_pkg.sv =====
// Shared types and constants for the hashed timing wheel core.
// Used by every module of the block; has no dependencies of its own.
package htw_pkg;

  // Default sizes of the wheel and the task table.
  localparam int unsigned WHEEL_SLOTS_DEF  = 10;
  localparam int unsigned TASK_ENTRIES_DEF = 16;

  // Field widths fixed by the channel format.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned TICK_W   = 3;

  // Slot and position width covers the largest supported wheel of 16 slots.
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned ROUNDS_W = 13;
  localparam logic [ROUNDS_W-1:0] ROUNDS_MAX = '1;
  localparam logic [TICK_W-1:0]   MAX_TICKS  = TICK_W'(4);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_REG   = 2'd1,
    OP_UNREG = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_e;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_REGW  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  // Input item.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   tick_count;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [ID_W-1:0] expired_task;
    logic            last_of_run;
  } out_t;

  // One task table entry. The reload values are the period split into
  // its slot offset and its round count, kept so that re-arming needs no divide.
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic [ROUNDS_W-1:0] rounds;
    logic [SLOT_W-1:0]   offset;
    logic [ROUNDS_W-1:0] reload;
  } entry_t;

  // Result of splitting a period by the wheel size.
  typedef struct packed {
    logic                valid;
    logic [SLOT_W-1:0]   offset;
    logic [ROUNDS_W-1:0] reload;
  } div_res_t;

  // Expiry handed from the sequencer to the output buffer.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
  } push_req_t;

  // Output buffer status back to the sequencer.
  typedef struct packed {
    logic push_ready;
    logic flush_done;
  } ob_stat_t;

endpackage

// ===== sv/htw_task_mem.sv =====
// Task table memory: one write port, one read port, registered read data.
// Depends on htw_pkg for the entry type.
module htw_task_mem #(
  parameter int unsigned Depth = htw_pkg::TASK_ENTRIES_DEF,
  parameter int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IdxW-1:0]   waddr_i,
  input  htw_pkg::entry_t   wdata_i,
  input  logic              re_i,
  input  logic [IdxW-1:0]   raddr_i,
  output htw_pkg::entry_t   rdata_o
);
  import htw_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a write to the same entry in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/htw_div.sv =====
// Splits a period into slot offset and round count by the wheel size.
// Two stages: reciprocal multiply, then one correction step. Uses htw_pkg.
module htw_div #(
  parameter int unsigned WheelSlots = htw_pkg::WHEEL_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [htw_pkg::PERIOD_W-1:0]  period_i,
  output htw_pkg::div_res_t             res_o
);
  import htw_pkg::*;

  localparam int unsigned Recip = (1 << PERIOD_W) / WheelSlots;
  localparam logic [PERIOD_W-1:0] RecipC = PERIOD_W'(Recip);
  localparam logic [SLOT_W:0]     SlotsC = (SLOT_W + 1)'(WheelSlots);

  logic                    v1_q, v2_q;
  logic [2*PERIOD_W-1:0]   prod_q;
  logic [PERIOD_W-1:0]     per_q;
  logic [SLOT_W-1:0]       offset_q;
  logic [ROUNDS_W-1:0]     reload_q;

  logic [PERIOD_W-1:0]        quot, quot_c;
  logic [PERIOD_W+SLOT_W:0]   qs, rem_full;
  logic [SLOT_W:0]            rem, rem_c;
  logic [ROUNDS_W-1:0]        reload_d;

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  // Stage one: the estimate is the true quotient or one below it.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= period_i * RecipC;
      per_q  <= period_i;
    end
  end

  // Stage two: remainder, one correction, saturate the round count.
  always_comb begin
    quot     = prod_q[2*PERIOD_W-1:PERIOD_W];
    qs       = quot * SlotsC;
    rem_full = {{(SLOT_W + 1){1'b0}}, per_q} - qs;
    rem      = rem_full[SLOT_W:0];
    if (rem >= SlotsC) begin
      quot_c = quot + PERIOD_W'(1);
      rem_c  = rem - SlotsC;
    end else begin
      quot_c = quot;
      rem_c  = rem;
    end
    if (quot_c > PERIOD_W'(ROUNDS_MAX)) begin
      reload_d = ROUNDS_MAX;
    end else begin
      reload_d = quot_c[ROUNDS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      offset_q <= rem_c[SLOT_W-1:0];
      reload_q <= reload_d;
    end
  end

  assign res_o.valid  = v2_q;
  assign res_o.offset = offset_q;
  assign res_o.reload = reload_q;

endmodule

// ===== sv/htw_out_buf.sv =====
// Result buffer: holds the latest expiry back until the next one or the end
// of the batch decides its last flag, then presents it on the output channel.
// Uses htw_pkg.
module htw_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htw_pkg::push_req_t  push_i,
  input  logic                flush_i,
  output htw_pkg::ob_stat_t   stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output htw_pkg::out_t       out_o
);
  import htw_pkg::*;

  logic            pend_valid_q;
  logic [ID_W-1:0] pend_id_q;
  logic            out_valid_q;
  out_t            out_q;

  logic out_free;
  logic load_out;
  logic load_last;

  // The output register can take a new item when empty or being drained.
  assign out_free  = !out_valid_q || out_ready_i;
  assign load_out  = pend_valid_q && out_free && (push_i.valid || flush_i);
  assign load_last = flush_i && !push_i.valid;

  assign stat_o.push_ready = !pend_valid_q || out_free;
  assign stat_o.flush_done = !pend_valid_q || out_free;

  // Pending expiry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (push_i.valid && stat_o.push_ready) begin
      pend_valid_q <= 1'b1;
    end else if (load_out) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && stat_o.push_ready) begin
      pend_id_q <= push_i.id;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q.expired_task <= pend_id_q;
      out_q.last_of_run  <= load_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== sv/hashed_timing_wheel_core.sv =====
// Hashed timing wheel core: a periodic timer table with a task memory,
// a period divider and a result buffer. Uses htw_pkg and all htw_ modules.
//
// Usage: items enter on in_valid_i/in_ready_o/in_i. A register item arms a
// task, an unregister item disarms it, a tick item advances the wheel by
// 1 to 4 ticks and reports each expiring task on out_valid_o/out_ready_i/
// out_o, in ascending task id within a tick, with last_of_run set on the
// final expiry of that tick item. Items producing no expiries produce no
// result items.
// Steps: unregister acts when accepted; register passes the accept
// and two divider stages, the table written in the last. A tick item
// scans all table entries once per tick: the scan reads one table
// entry per cycle from the task memory unless an expiry stalls it,
// with its read-modify-write pipelined one entry behind the read,
// and then the held last expiry is released.
// Reset clears all valid bits and the wheel position; the table needs no
// clearing pass. A stalled output receiver holds the scan only when an
// expiry finds both the pending and the output register occupied, and the
// release of the last expiry waits the same way; a new item is accepted
// while the final result still waits in the output register.
module hashed_timing_wheel_core #(
  parameter int unsigned WheelSlots  = htw_pkg::WHEEL_SLOTS_DEF,
  parameter int unsigned TaskEntries = htw_pkg::TASK_ENTRIES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  htw_pkg::in_t   in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output htw_pkg::out_t  out_o
);
  import htw_pkg::*;

  localparam int unsigned IdxW = (TaskEntries > 1) ? $clog2(TaskEntries) : 1;
  localparam logic [IdxW-1:0]   LastIdx  = IdxW'(TaskEntries - 1);
  localparam logic [SLOT_W-1:0] LastPos  = SLOT_W'(WheelSlots - 1);
  localparam logic [SLOT_W:0]   SlotsC   = (SLOT_W + 1)'(WheelSlots);

  state_e state_q, state_d;

  logic [TaskEntries-1:0] valid_q;
  logic [SLOT_W-1:0]      pos_q;
  logic [IdxW-1:0]        reg_idx_q;

  logic [IdxW-1:0]        rd_idx_q;
  logic [TICK_W-1:0]      rd_ticks_q;
  logic                   ev_valid_q;
  logic [IdxW-1:0]        ev_idx_q;
  logic [TICK_W-1:0]      ev_ticks_q;

  logic                   accept;
  logic [IdxW+ID_W-1:0]   id_wide;
  logic [IdxW-1:0]        id_addr;
  logic                   id_in_range;
  logic [TICK_W-1:0]      ticks_clamped;
  logic                   start_reg;
  logic                   start_tick;
  logic                   do_unreg;

  div_res_t               div_res;
  entry_t                 rd_data;
  entry_t                 wr_data;
  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic                   rd_en;

  logic                   hit;
  logic                   fire;
  logic                   stall;
  logic                   ev_step;
  logic                   tick_end;
  logic [SLOT_W:0]        rearm_sum;
  logic [SLOT_W-1:0]      rearm_slot;
  logic [SLOT_W:0]        place_sum;
  logic [SLOT_W-1:0]      place_slot;
  logic [IdxW+ID_W-1:0]   ev_wide;

  push_req_t              push;
  ob_stat_t               ob_stat;

  // Input decode.
  assign in_ready_o    = (state_q == ST_IDLE);
  assign accept        = in_valid_i && in_ready_o;
  assign id_wide       = {{IdxW{1'b0}}, in_i.task_id};
  assign id_addr       = id_wide[IdxW-1:0];
  assign id_in_range   = (id_wide < (IdxW + ID_W)'(TaskEntries));
  assign ticks_clamped = (in_i.tick_count > MAX_TICKS) ? MAX_TICKS : in_i.tick_count;
  assign start_reg     = accept && (in_i.opcode == OP_REG) && id_in_range;
  assign do_unreg      = accept && (in_i.opcode == OP_UNREG) && id_in_range;
  assign start_tick    = accept && (in_i.opcode == OP_TICK) && (ticks_clamped != '0);

  // Period divider for register items.
  htw_div #(
    .WheelSlots (WheelSlots)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_reg),
    .period_i (in_i.period),
    .res_o    (div_res)
  );

  // Evaluation of the registered entry read by the scan.
  assign hit   = ev_valid_q && (state_q == ST_SCAN) && valid_q[ev_idx_q]
                 && (rd_data.slot == pos_q);
  assign fire  = hit && (rd_data.rounds == '0);
  assign stall = fire && !ob_stat.push_ready;
  assign ev_step  = ev_valid_q && (state_q == ST_SCAN) && !stall;
  assign tick_end = ev_step && (ev_idx_q == LastIdx);

  // Re-armed slot: offset plus current position, wrapped once.
  assign rearm_sum  = {1'b0, rd_data.offset} + {1'b0, pos_q};
  assign rearm_slot = (rearm_sum >= SlotsC) ? SLOT_W'(rearm_sum - SlotsC)
                                            : rearm_sum[SLOT_W-1:0];
  assign place_sum  = {1'b0, div_res.offset} + {1'b0, pos_q};
  assign place_slot = (place_sum >= SlotsC) ? SLOT_W'(place_sum - SlotsC)
                                            : place_sum[SLOT_W-1:0];

  // Table write port: register writes a new entry, the scan updates in place.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ev_idx_q;
    wr_data   = rd_data;
    if ((state_q == ST_REGW) && div_res.valid) begin
      mem_we         = 1'b1;
      mem_waddr      = reg_idx_q;
      wr_data.slot   = place_slot;
      wr_data.rounds = div_res.reload;
      wr_data.offset = div_res.offset;
      wr_data.reload = div_res.reload;
    end else if (hit && !stall) begin
      mem_we = 1'b1;
      if (fire) begin
        wr_data.slot   = rearm_slot;
        wr_data.rounds = rd_data.reload;
      end else begin
        wr_data.rounds = rd_data.rounds - ROUNDS_W'(1);
      end
    end
  end

  assign rd_en = (state_q == ST_SCAN) && (rd_ticks_q != '0) && !stall;

  htw_task_mem #(
    .Depth (TaskEntries),
    .IdxW  (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  // Expiries go to the result buffer.
  assign ev_wide    = {{ID_W{1'b0}}, ev_idx_q};
  assign push.valid = fire;
  assign push.id    = ev_wide[ID_W-1:0];

  htw_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .flush_i     (state_q == ST_FLUSH),
    .stat_o      (ob_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_reg) begin
          state_d = ST_REGW;
        end else if (start_tick) begin
          state_d = ST_SCAN;
        end
      end
      ST_REGW: begin
        if (div_res.valid) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (tick_end && (ev_ticks_q == TICK_W'(1))) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (ob_stat.flush_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Register target index.
  always_ff @(posedge clk_i) begin
    if (start_reg) begin
      reg_idx_q <= id_addr;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_unreg) begin
      valid_q[id_addr] <= 1'b0;
    end else if ((state_q == ST_REGW) && div_res.valid) begin
      valid_q[reg_idx_q] <= 1'b1;
    end
  end

  // Read side of the scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      rd_ticks_q <= '0;
    end else if (start_tick) begin
      rd_idx_q   <= '0;
      rd_ticks_q <= ticks_clamped;
    end else if (rd_en) begin
      if (rd_idx_q == LastIdx) begin
        rd_idx_q   <= '0;
        rd_ticks_q <= rd_ticks_q - TICK_W'(1);
      end else begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
    end
  end

  // Evaluate side of the scan and the wheel position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
      ev_idx_q   <= '0;
      ev_ticks_q <= '0;
      pos_q      <= '0;
    end else begin
      if (start_tick) begin
        ev_valid_q <= 1'b0;
        ev_ticks_q <= ticks_clamped;
      end else if (!stall) begin
        ev_valid_q <= rd_en;
        ev_idx_q   <= rd_idx_q;
      end
      if (tick_end) begin
        ev_ticks_q <= ev_ticks_q - TICK_W'(1);
        pos_q      <= (pos_q == LastPos) ? '0 : pos_q + SLOT_W'(1);
      end
    end
  end

  // A stalled expiry keeps its entry in the evaluate stage.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> (ev_valid_q && $stable(ev_idx_q)))
    else $error("stalled scan entry was not held");

  // The scan is fully drained whenever new items are taken.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!ev_valid_q && (rd_ticks_q == '0)))
    else $error("scan pipeline busy while idle");

  // The wheel position stays inside the wheel.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < SlotsC)
    else $error("wheel position out of range");

  // Expiries are only raised during a scan.
  a_push_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> (state_q == ST_SCAN))
    else $error("expiry outside of a scan");

endmodule

// ===== verif/hashed_timing_wheel_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hashed_timing_wheel_core: a directed table, then random items
// under several idle and stall patterns, all checked against a predictor of the timer table.
// Depends on htw_pkg and the hashed_timing_wheel_core RTL only.
module hashed_timing_wheel_core_tb;
  import htw_pkg::*;

  localparam int unsigned SLOTS          = WHEEL_SLOTS_DEF;
  localparam int unsigned ENTRIES        = TASK_ENTRIES_DEF;
  localparam int unsigned DRAIN_CYCLES   = 4 * ENTRIES + 16;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned RAND_PER_PHASE = 43;
  localparam int unsigned PHASES         = 4;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_MODEL = 2'd0,
    CHK_NONE  = 2'd1,
    CHK_ONE   = 2'd2
  } chk_e;

  typedef struct packed {
    in_t  item;
    chk_e chk;
    out_t given;
  } row_t;

  localparam out_t NO_RES = '0;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_i        = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_o;

  hashed_timing_wheel_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #1 clk_i = ~clk_i;

  // Predicted copy of the task table and the wheel.
  logic                tab_valid  [ENTRIES];
  logic [PERIOD_W-1:0] tab_period [ENTRIES];
  logic [SLOT_W-1:0]   tab_slot   [ENTRIES];
  logic [ROUNDS_W-1:0] tab_rounds [ENTRIES];
  logic [SLOT_W-1:0]   wheel_pos;

  out_t        fired_now [$];
  out_t        expiry_q  [$];
  int unsigned err_cnt      = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_seq     = 0;

  initial begin
    for (int e = 0; e < ENTRIES; e++) begin
      tab_valid[e] = 1'b0;
    end
    wheel_pos = '0;
  end

  // Directed items: extremes, every operation and the special cases.
  row_t dir_rows [25] = '{
    '{'{OP_TICK,  4'd0,  16'd0,     3'd1}, CHK_NONE,  NO_RES},
    '{'{OP_RSVD,  4'd15, 16'hFFFF,  3'd7}, CHK_NONE,  NO_RES},
    '{'{OP_UNREG, 4'd5,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_TICK,  4'd0,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_REG,   4'd0,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_TICK,  4'd0,  16'd0,     3'd4}, CHK_ONE,   '{4'd0, 1'b1}},
    '{'{OP_REG,   4'd15, 16'hFFFF,  3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_REG,   4'd3,  16'd1,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_REG,   4'd3,  16'd2,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_REG,   4'd7,  16'd1,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_TICK,  4'd0,  16'd0,     3'd7}, CHK_MODEL, NO_RES},
    '{'{OP_UNREG, 4'd7,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_TICK,  4'd9,  16'hA5A5,  3'd5}, CHK_MODEL, NO_RES},
    '{'{OP_REG,   4'd10, 16'd10,    3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_REG,   4'd9,  16'd9,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_REG,   4'd12, 16'd12345, 3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_TICK,  4'd0,  16'd0,     3'd4}, CHK_MODEL, NO_RES},
    '{'{OP_TICK,  4'd0,  16'd0,     3'd3}, CHK_MODEL, NO_RES},
    '{'{OP_UNREG, 4'd0,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_UNREG, 4'd15, 16'hFFFF,  3'd7}, CHK_NONE,  NO_RES},
    '{'{OP_UNREG, 4'd3,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_UNREG, 4'd10, 16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_UNREG, 4'd9,  16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_UNREG, 4'd12, 16'd0,     3'd0}, CHK_NONE,  NO_RES},
    '{'{OP_TICK,  4'd0,  16'd0,     3'd4}, CHK_NONE,  NO_RES}
  };

  // Place a task on the wheel relative to the current position.
  function automatic void arm_task(input int unsigned id, input logic [PERIOD_W-1:0] per);
    int unsigned rnd;
    rnd = per / SLOTS;
    if (rnd > ROUNDS_MAX) begin
      rnd = ROUNDS_MAX;
    end
    tab_period[id] = per;
    tab_slot[id]   = SLOT_W'((per % SLOTS + wheel_pos) % SLOTS);
    tab_rounds[id] = ROUNDS_W'(rnd);
    tab_valid[id]  = 1'b1;
  endfunction

  // Apply one item to the predicted table and collect the expiries it causes.
  function automatic void wheel_apply(input in_t item);
    int unsigned n_ticks;
    int unsigned ids [$];
    logic        due [ENTRIES];
    out_t        res;
    fired_now.delete();
    case (item.opcode)
      OP_REG: begin
        if (item.task_id < ENTRIES) begin
          arm_task(32'(item.task_id), item.period);
        end
      end
      OP_UNREG: begin
        if (item.task_id < ENTRIES) begin
          tab_valid[item.task_id] = 1'b0;
        end
      end
      OP_TICK: begin
        n_ticks = 32'((item.tick_count > MAX_TICKS) ? MAX_TICKS : item.tick_count);
        for (int t = 0; t < n_ticks; t++) begin
          // Visit the current slot: expire tasks out of rounds, count down the rest.
          for (int e = 0; e < ENTRIES; e++) begin
            due[e] = 1'b0;
            if (tab_valid[e] && tab_slot[e] == wheel_pos) begin
              if (tab_rounds[e] == '0) begin
                due[e] = 1'b1;
              end else begin
                tab_rounds[e] = tab_rounds[e] - 1'b1;
              end
            end
          end
          for (int e = 0; e < ENTRIES; e++) begin
            if (due[e]) begin
              ids.insert(ids.size(), e);
              arm_task(e, tab_period[e]);
            end
          end
          wheel_pos = SLOT_W'((wheel_pos + 1) % SLOTS);
        end
      end
      default: begin
      end
    endcase
    foreach (ids[i]) begin
      res.expired_task = ID_W'(ids[i]);
      res.last_of_run  = (i == ids.size() - 1);
      fired_now.insert(fired_now.size(), res);
    end
  endfunction

  // Random item, mostly registers and ticks with small periods so tasks fire often.
  function automatic in_t rand_item();
    in_t         it;
    int unsigned pick;
    it.task_id    = ID_W'($urandom_range(15));
    it.period     = PERIOD_W'($urandom);
    it.tick_count = TICK_W'($urandom_range(7));
    pick = $urandom_range(99);
    if (pick < 30) begin
      it.opcode = OP_REG;
      pick = $urandom_range(9);
      if (pick < 6) begin
        it.period = PERIOD_W'($urandom_range(25));
      end else if (pick < 9) begin
        it.period = PERIOD_W'($urandom_range(300));
      end
    end else if (pick < 40) begin
      it.opcode = OP_UNREG;
    end else if (pick < 95) begin
      it.opcode = OP_TICK;
      if ($urandom_range(9) < 8) begin
        it.tick_count = TICK_W'($urandom_range(4, 1));
      end
    end else begin
      it.opcode = OP_RSVD;
    end
    return it;
  endfunction

  // Sender: optional idle gap, then hold the item until it is accepted.
  task automatic offer(input in_t item, input chk_e chk, input out_t given);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_i       <= item;
    in_valid_i <= 1'b1;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    wheel_apply(item);
    case (chk)
      CHK_MODEL: begin
        foreach (fired_now[i]) begin
          expiry_q.insert(expiry_q.size(), fired_now[i]);
        end
      end
      CHK_ONE: expiry_q.insert(expiry_q.size(), given);
      default: begin
      end
    endcase
  endtask

  // Stop offering until every expected expiry has come out, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expiry_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : rx_side
    int unsigned seen;
    int unsigned left;
    seen = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != seen) begin
        seen = hold_seq;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Check each result item in the cycle before the edge that accepts it.
  always @(negedge clk_i) begin : chk_out
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expiry_q.size() == 0) begin
        $display("%0t: unexpected expiry, got task %0d last %0b", $time,
                 out_o.expired_task, out_o.last_of_run);
        err_cnt++;
      end else begin
        want = expiry_q.pop_front();
        if (out_o.expired_task != want.expired_task) begin
          $display("%0t: expired_task expected %0d, got %0d", $time,
                   want.expired_task, out_o.expired_task);
          err_cnt++;
        end
        if (out_o.last_of_run != want.last_of_run) begin
          $display("%0t: last_of_run expected %0b, got %0b", $time,
                   want.last_of_run, out_o.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, back-pressure burst, random phases.
  initial begin : stim
    in_t         it;
    int unsigned done_n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      offer(dir_rows[r].item, dir_rows[r].chk, dir_rows[r].given);
    end

    // Every task fires on every tick while the receiver holds off.
    for (int id = 0; id < ENTRIES; id++) begin
      it         = '0;
      it.opcode  = OP_REG;
      it.task_id = ID_W'(id);
      it.period  = 16'd1;
      offer(it, CHK_MODEL, NO_RES);
    end
    hold_seq <= hold_seq + 1;
    it            = '0;
    it.opcode     = OP_TICK;
    it.tick_count = 3'd4;
    repeat (6) offer(it, CHK_MODEL, NO_RES);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: begin
          tx_idle_pct = 77;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 77;
        end
        3: begin
          tx_idle_pct = 6;
          rx_stall_pct <= 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
      endcase
      done_n = 0;
      while (done_n < RAND_PER_PHASE) begin
        it = rand_item();
        if (!(it.opcode == OP_RSVD || (it.opcode == OP_TICK && it.tick_count == 0))) begin
          done_n++;
        end
        offer(it, CHK_MODEL, NO_RES);
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("hashed_timing_wheel_core_tb: done, clean");
    end else begin
      $display("hashed_timing_wheel_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4000000;
    $display("hashed_timing_wheel_core_tb: done, errors");
    $finish;
  end

endmodule
